[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the indexed list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHECK_IMPL(lbl, ante, cons, msg)
`define CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/ilws_pkg.sv]
// Types, constants and codes shared by the indexed list block.
package ilws_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = 7;
    localparam int CNT_W       = IDX_W;
    localparam int ADDR_W      = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                    op;
        logic [IDX_W-1:0]       index;
        logic [VALUE_WIDTH-1:0] value;
    } item_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] data;
        status_t                status;
        logic [CNT_W-1:0]       count;
        logic [CNT_W-1:0]       capacity;
    } result_t;

    // Read address sources of the entry memory.
    typedef enum logic [2:0] {
        RD_POS        = 3'd0,
        RD_UP_FIRST   = 3'd1,
        RD_UP         = 3'd2,
        RD_DOWN_FIRST = 3'd3,
        RD_DOWN       = 3'd4
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_VALUE = 1'b1
    } wr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD = 3'd0,
        PTR_USED = 3'd1,
        PTR_POS  = 3'd2,
        PTR_DEC  = 3'd3,
        PTR_INC  = 3'd4
    } ptr_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        ptr_op_t ptr_op;
        logic    grab;
        logic    finish;
    } ctl_t;

    typedef struct packed {
        logic err;
        logic put;
        logic remove;
        logic set_over;
        logic up_need;
        logic up_more;
        logic grab_more;
        logic down_more;
    } stat_t;

endpackage

[src/indexed_list_with_shift.sv]
// Top level of the indexed list with shift: controller, datapath and checks.
//
// Input channel item (op, index, value) and result channel result (data, status,
// count, capacity) both use valid/stall; an item moves on a clock edge with valid
// high and stall low. One result comes back for every item, in order.
// The list lives in a 64-entry single-port-read, single-port-write memory, so a
// shift moves one entry per cycle, pipelined through the registered read port.
// An error goes from the check straight to the result. Get and set of an existing
// entry read it, and set writes the new value. Insert shifts the entries from index
// up one place, then writes the value; remove shifts the entries above index down.
// The block takes one item at a time; item_stall is high from acceptance until the
// result is loaded. The result register holds a finished result while the receiver
// stalls; the next item is accepted meanwhile and waits in its last step until the
// register frees. Reset (rst_n low, asynchronous) empties the list and sets the
// capacity to 1; memory contents need no clearing.
module indexed_list_with_shift (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ilws_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ilws_pkg::result_t result
);
    import ilws_pkg::*;

`include "assert_macros.svh"

    ctl_t  ctl;
    stat_t stat;

    ilws_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .ctl          (ctl),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    ilws_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

    `CHECK_NEXT(busy_after_accept, item_valid && !item_stall, item_stall, "accepted item did not make the block busy")
    `CHECK_IMPL(finish_needs_room, ctl.finish, !result_valid || !result_stall, "result loaded over a stalled result")
    `CHECK_IMPL(capacity_bound, result_valid, (result.count <= result.capacity) && $onehot(result.capacity), "capacity is not a power of two at or above count")

endmodule

[src/ilws_dp.sv]
// Datapath of the indexed list: entry memory, item and count registers, result register.
module ilws_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  ilws_pkg::item_t  item,
    input  ilws_pkg::ctl_t   ctl,
    output ilws_pkg::stat_t  stat,
    output ilws_pkg::result_t result
);
    import ilws_pkg::*;

    logic [VALUE_WIDTH-1:0] entries_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    item_t                  item_reg;
    logic [VALUE_WIDTH-1:0] data_reg;
    logic [CNT_W-1:0]       ptr_reg;
    logic [CNT_W-1:0]       ptr_next;
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       used_next;
    logic [CNT_W-1:0]       room_reg;
    logic [CNT_W-1:0]       room_next;
    result_t                result_reg;

    logic [IDX_W-1:0]       pos;
    logic                   full;
    status_t                status;
    logic [CNT_W-1:0]       rd_full;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    // Halve the capacity while the count is below a quarter of it; an empty list gets 1.
    function automatic logic [CNT_W-1:0] settle_room(input logic [CNT_W-1:0] room,
                                                     input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] r;
        r = room;
        if (cnt == '0)
        begin
            r = CNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < CNT_W; i++)
            begin
                if (r != CNT_W'(1) && cnt < (r >> 2))
                begin
                    r = r >> 1;
                end
            end
        end
        return r;
    endfunction

    assign pos  = item_reg.index;
    assign full = (used_reg == CNT_W'(DEPTH));

    always_comb
    begin
        status = ST_OK;
        case (item_reg.op) inside
            OP_INSERT:
            begin
                if (pos > used_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
            end
            OP_REMOVE, OP_GET:
            begin
                if (pos >= used_reg)
                begin
                    status = ST_RANGE;
                end
            end
            default:
            begin
                if (pos > used_reg)
                begin
                    status = ST_RANGE;
                end
                else if (pos == used_reg && full)
                begin
                    status = ST_FULL;
                end
            end
        endcase
    end

    always_comb
    begin
        stat.err       = (status != ST_OK);
        stat.put       = (status == ST_OK) && ((item_reg.op == OP_INSERT) ||
                         (item_reg.op == OP_SET && pos == used_reg));
        stat.remove    = (status == ST_OK) && (item_reg.op == OP_REMOVE);
        stat.set_over  = (status == ST_OK) && (item_reg.op == OP_SET) && (pos < used_reg);
        stat.up_need   = (used_reg > pos);
        stat.up_more   = ((ptr_reg - CNT_W'(1)) > pos);
        stat.grab_more = ((ptr_reg + CNT_W'(1)) < used_reg);
        stat.down_more = ((ptr_reg + CNT_W'(2)) < used_reg);
    end

    always_comb
    begin
        case (ctl.rd_sel)
            RD_POS:        rd_full = pos;
            RD_UP_FIRST:   rd_full = used_reg - CNT_W'(1);
            RD_UP:         rd_full = ptr_reg - CNT_W'(2);
            RD_DOWN_FIRST: rd_full = ptr_reg + CNT_W'(1);
            RD_DOWN:       rd_full = ptr_reg + CNT_W'(2);
            default:       rd_full = pos;
        endcase
    end

    assign rd_addr = rd_full[ADDR_W-1:0];
    assign wr_addr = (ctl.wr_sel == WR_VALUE) ? pos[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign wr_data = (ctl.wr_sel == WR_VALUE) ? item_reg.value : rd_data_reg;

    always_comb
    begin
        case (ctl.ptr_op)
            PTR_USED: ptr_next = used_reg;
            PTR_POS:  ptr_next = pos;
            PTR_DEC:  ptr_next = ptr_reg - CNT_W'(1);
            PTR_INC:  ptr_next = ptr_reg + CNT_W'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        room_next = room_reg;
        if (stat.put)
        begin
            used_next = used_reg + CNT_W'(1);
            room_next = (used_reg == room_reg) ? (room_reg << 1) : room_reg;
        end
        else if (stat.remove)
        begin
            used_next = used_reg - CNT_W'(1);
            room_next = settle_room(room_reg, used_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= entries_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.load)
        begin
            item_reg <= item;
            data_reg <= '0;
        end
        else if (ctl.grab)
        begin
            data_reg <= rd_data_reg;
        end
        if (ctl.finish)
        begin
            result_reg.data     <= data_reg;
            result_reg.status   <= status;
            result_reg.count    <= used_next;
            result_reg.capacity <= room_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            room_reg <= CNT_W'(1);
        end
        else if (ctl.finish)
        begin
            used_reg <= used_next;
            room_reg <= room_next;
        end
    end

    assign result = result_reg;

endmodule

[src/ilws_ctrl.sv]
// Controller of the indexed list: sequences checks, memory moves and result hand-off.
module ilws_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            result_stall,
    input  ilws_pkg::stat_t stat,
    output ilws_pkg::ctl_t  ctl,
    output logic            item_stall,
    output logic            result_valid
);
    import ilws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_PUT,
        S_GRAB,
        S_DOWN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '{load: 1'b0, rd_en: 1'b0, rd_sel: RD_POS, wr_en: 1'b0,
                       wr_sel: WR_SHIFT, ptr_op: PTR_HOLD, grab: 1'b0, finish: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.err)
                begin
                    state_next = S_DONE;
                end
                else if (stat.put)
                begin
                    if (stat.up_need)
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_UP_FIRST;
                        ctl.ptr_op = PTR_USED;
                        state_next = S_UP;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_POS;
                    ctl.ptr_op = PTR_POS;
                    state_next = S_GRAB;
                end
            end
            S_UP:
            begin
                // Write the word read last cycle one place up, and fetch the next lower one.
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_SHIFT;
                ctl.ptr_op = PTR_DEC;
                if (stat.up_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_UP;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_VALUE;
                state_next = S_DONE;
            end
            S_GRAB:
            begin
                ctl.grab   = 1'b1;
                state_next = S_DONE;
                if (stat.remove && stat.grab_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_DOWN_FIRST;
                    state_next = S_DOWN;
                end
                else if (stat.set_over)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WR_VALUE;
                end
            end
            S_DOWN:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_SHIFT;
                ctl.ptr_op = PTR_INC;
                if (stat.down_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_DOWN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule
